// File: rtl/base6_to_radix_m_converter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the base-6 to radix-m converter
// Clocked property checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BASE6_TO_RADIX_M_CONVERTER_ASSERT_SVH
`define BASE6_TO_RADIX_M_CONVERTER_ASSERT_SVH

`ifndef SYNTHESIS
// Checks that the property holds at every rising clock edge outside reset.
`define B6RM_ASSERT(lbl, clock, reset, prop, msg) \
  lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Checks that the expression is never true at a rising clock edge outside reset.
`define B6RM_NEVER(lbl, clock, reset, expr, msg) \
  lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);
`else
`define B6RM_ASSERT(lbl, clock, reset, prop, msg)
`define B6RM_NEVER(lbl, clock, reset, expr, msg)
`endif

`endif

// File: rtl/b6rm_pkg.sv
// ----------------------------------------------------------------------------
// b6rm_pkg
// Shared constants, types and helper functions of the base-6 converter.
// ----------------------------------------------------------------------------
package b6rm_pkg;

  localparam int ACC_W          = 37;
  localparam int MAX_IN_DIGITS  = 14;
  localparam int MAX_OUT_DIGITS = 37;
  localparam int CNT_W          = 4;
  localparam int RADIX_W        = 5;
  localparam int DIGIT_W        = 3;
  localparam int CHAR_W         = 7;
  localparam int REM_W          = 5;
  localparam int BASE_IN        = 6;
  localparam int PTR_W          = $clog2(MAX_OUT_DIGITS + 1);
  localparam int IDX_W          = $clog2(MAX_OUT_DIGITS);
  localparam int DIV_CNT_W      = $clog2(ACC_W + 1);

  localparam logic [DIGIT_W-1:0] DIGIT_MAX   = DIGIT_W'(5);
  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(20);
  localparam logic [CHAR_W-1:0]  ASCII_ZERO  = CHAR_W'(48);
  localparam logic [CHAR_W-1:0]  ASCII_A     = CHAR_W'(65);
  localparam logic [REM_W-1:0]   DEC_DIGITS  = REM_W'(10);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_DIV,
    S_READ,
    S_SEND
  } state_t;

  typedef struct packed {
    logic               start;
    logic [RADIX_W-1:0] divisor;
    logic [ACC_W-1:0]   dividend;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [ACC_W-1:0] quot;
    logic [REM_W-1:0] rem;
  } div_rsp_t;

  function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) res = RADIX_MIN;
    if (r > RADIX_MAX) res = RADIX_MAX;
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] to_ascii(input logic [REM_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_DIGITS) begin
      c = ASCII_ZERO + CHAR_W'(d);
    end else begin
      c = ASCII_A + CHAR_W'(d - DEC_DIGITS);
    end
    return c;
  endfunction

endpackage

// File: rtl/b6rm_div.sv
// ----------------------------------------------------------------------------
// b6rm_div
// Restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module b6rm_div (
  input  logic              clk,
  input  logic              rst,
  input  b6rm_pkg::div_req_t req,
  output b6rm_pkg::div_rsp_t rsp
);
  import b6rm_pkg::*;

  logic [ACC_W-1:0]     quo;
  logic [REM_W-1:0]     rem;
  logic [RADIX_W-1:0]   divisor;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 running;
  logic                 done;

  logic [REM_W:0]       trial;
  logic                 fits;

  // The partial remainder stays below the divisor, so one more bit fits in REM_W+1 bits.
  assign trial = {rem, quo[ACC_W-1]};
  assign fits  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        cnt     <= DIV_CNT_W'(ACC_W);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo     <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (running) begin
      quo <= {quo[ACC_W-2:0], fits};
      rem <= fits ? REM_W'(trial - {1'b0, divisor}) : REM_W'(trial);
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quo;
  assign rsp.rem  = rem;

endmodule

// File: rtl/base6_to_radix_m_converter.sv
// ----------------------------------------------------------------------------
// base6_to_radix_m_converter
// Accumulates a base-6 number and prints it as ASCII digits in radix 2..20.
// ----------------------------------------------------------------------------
// Non-final digits can follow back to back. After the final digit the block
// stops taking input while it converts and emits: for every output digit it
// starts the bit-serial divider, waits for it to finish and stores the
// remainder, and each character is then read from the digit store and
// presented, held while out_stall is high. A number has at most 37 output
// digits (radix 2). The radix register may be written only while no number
// is being converted or emitted.
module base6_to_radix_m_converter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [b6rm_pkg::RADIX_W-1:0]   cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [b6rm_pkg::DIGIT_W-1:0]   digit,
  input  logic                           last_digit,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [b6rm_pkg::CHAR_W-1:0]    out_char,
  output logic                           last_char,
  output logic                           overflow
);
  import b6rm_pkg::*;

  state_t             st;
  state_t             st_next;
  logic [RADIX_W-1:0] radix;
  logic [ACC_W-1:0]   acc;
  logic [CNT_W-1:0]   digit_count;
  logic               ovf;
  logic [PTR_W-1:0]   n;
  logic [PTR_W-1:0]   rd_ptr;
  logic [REM_W-1:0]   rd_data;
  logic [REM_W-1:0]   mem [MAX_OUT_DIGITS];

  div_req_t           div_req;
  div_rsp_t           div_rsp;
  logic               in_acc;
  logic               out_acc;
  logic [DIGIT_W-1:0] dsat;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign dsat    = (digit > DIGIT_MAX) ? DIGIT_MAX : digit;

  b6rm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    st_next = st;
    case (st)
      S_IDLE:  if (in_acc && last_digit) st_next = S_START;
      S_START: st_next = S_DIV;
      S_DIV: begin
        if (div_rsp.done) begin
          st_next = (div_rsp.quot == '0) ? S_READ : S_START;
        end
      end
      S_READ:  st_next = S_SEND;
      S_SEND: begin
        if (out_acc) begin
          st_next = (rd_ptr == '0) ? S_IDLE : S_READ;
        end
      end
      default: st_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall         = (st != S_IDLE);
    out_valid        = (st == S_SEND);
    div_req.start    = (st == S_START);
    div_req.divisor  = eff_radix(radix);
    div_req.dividend = acc;
    out_char         = to_ascii(rd_data);
    last_char        = (rd_ptr == '0);
    overflow         = ovf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= S_IDLE;
      radix       <= RADIX_RESET;
      acc         <= '0;
      digit_count <= '0;
      ovf         <= 1'b0;
      n           <= '0;
      rd_ptr      <= '0;
    end else begin
      st <= st_next;
      if (cfg_we) begin
        radix <= cfg_wdata;
      end
      case (st)
        S_IDLE: begin
          if (in_acc) begin
            if (digit_count < CNT_W'(MAX_IN_DIGITS)) begin
              acc         <= ACC_W'(acc * ACC_W'(BASE_IN)) + ACC_W'(dsat);
              digit_count <= digit_count + 1'b1;
            end else begin
              ovf <= 1'b1;
            end
            n <= '0;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            acc    <= div_rsp.quot;
            n      <= n + 1'b1;
            rd_ptr <= n;
          end
        end
        S_SEND: begin
          if (out_acc) begin
            if (rd_ptr == '0) begin
              acc         <= '0;
              digit_count <= '0;
              ovf         <= 1'b0;
            end else begin
              rd_ptr <= rd_ptr - 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Remainders land least significant first; the emit pass reads them back downward.
  always_ff @(posedge clk) begin
    if (st == S_DIV && div_rsp.done) begin
      mem[n[IDX_W-1:0]] <= div_rsp.rem;
    end
    if (st == S_READ) begin
      rd_data <= mem[rd_ptr[IDX_W-1:0]];
    end
  end

`include "base6_to_radix_m_converter_assert.svh"

  `B6RM_ASSERT(a_cnt_limit, clk, rst, digit_count <= CNT_W'(MAX_IN_DIGITS), "digit count past limit")
  `B6RM_ASSERT(a_n_limit, clk, rst, n <= PTR_W'(MAX_OUT_DIGITS), "digit store overrun")
  `B6RM_ASSERT(a_send_ptr, clk, rst, (st == S_SEND) |-> (rd_ptr < n), "read pointer outside digits")
  `B6RM_NEVER(a_div_done, clk, rst, div_rsp.done && (st != S_DIV), "divider finished unexpectedly")

endmodule
